// ----- hdl/ffsa_pkg.sv -----
`default_nettype none

package ffsa_pkg;

   localparam int DEF_MAX_SLOTS = 64;
   localparam int DEF_SIZE_BITS = 16;
   localparam int BUFFER_RESET  = 1024;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_REUSED     = 3'd0,
      ST_NEW        = 3'd1,
      ST_NO_SPACE   = 3'd2,
      ST_TABLE_FULL = 3'd3,
      ST_FREED      = 3'd4,
      ST_NOT_FOUND  = 3'd5
   } status_type;

endpackage

`default_nettype wire

// ----- hdl/ffsa_req_if.sv -----
`default_nettype none

interface ffsa_req_if
   import ffsa_pkg::*;
#(
   parameter int SIZE_BITS = DEF_SIZE_BITS
);
   logic                 valid;
   logic                 ready;
   func_type             func;
   logic [SIZE_BITS-1:0] req_size;
   logic [SIZE_BITS-1:0] free_offset;

   modport source (output valid, func, req_size, free_offset, input ready);
   modport sink   (input valid, func, req_size, free_offset, output ready);
endinterface

`default_nettype wire

// ----- hdl/ffsa_rsp_if.sv -----
`default_nettype none

interface ffsa_rsp_if
   import ffsa_pkg::*;
#(
   parameter int SIZE_BITS = DEF_SIZE_BITS
);
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [SIZE_BITS-1:0] alloc_offset;
   logic [SIZE_BITS-1:0] reserved_total;

   modport source (output valid, status, alloc_offset, reserved_total, input ready);
   modport sink   (input valid, status, alloc_offset, reserved_total, output ready);
endinterface

`default_nettype wire

// ----- hdl/ffsa_csr_if.sv -----
`default_nettype none

interface ffsa_csr_if
   import ffsa_pkg::*;
#(
   parameter int SIZE_BITS = DEF_SIZE_BITS
);
   logic                 valid;
   logic                 ready;
   logic [SIZE_BITS-1:0] buffer_bytes;

   modport source (output valid, buffer_bytes, input ready);
   modport sink   (input valid, buffer_bytes, output ready);
endinterface

`default_nettype wire

// ----- hdl/first_fit_slot_allocator_unit.sv -----
`default_nettype none

// Channel   Bus       Direction  Word
// request   req_bus   in         func, req_size, free_offset
// result    rsp_bus   out        status, alloc_offset, reserved_total
// config    csr_bus   in         buffer_bytes (always ready)
//
// A request walks the table from slot 0 through the single slot table read port
// and stops at the first match; a request that finds no match checks every slot
// in use, and with an empty table it checks no slot.
// Reset clears the slot count, the reserved total and the result valid, and
// sets buffer_bytes to 1024; table entries at or above the count are never checked.
// A result waiting on rsp_bus does not block acceptance of the next request,
// which walks the table and then holds until the result register is free.

module first_fit_slot_allocator_unit
   import ffsa_pkg::*;
#(
   parameter int MAX_SLOTS = DEF_MAX_SLOTS,
   parameter int SIZE_BITS = DEF_SIZE_BITS
) (
   input  wire          clock,
   input  wire          reset,
   ffsa_req_if.sink     req_bus,
   ffsa_rsp_if.source   rsp_bus,
   ffsa_csr_if.sink     csr_bus
);

   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int IDX_W = $clog2(MAX_SLOTS);

   typedef struct packed {
      logic                 busy;
      logic [SIZE_BITS-1:0] bytes;
      logic [SIZE_BITS-1:0] start;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [SIZE_BITS-1:0] buffer_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SIZE_BITS-1:0] reserved_ff, reserved_in;

   func_type             func_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [SIZE_BITS-1:0] foff_ff;

   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 chk_ff, chk_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   entry_type            hit_slot_ff, hit_slot_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [SIZE_BITS-1:0] offset_ff, offset_in;
   logic [SIZE_BITS-1:0] total_ff, total_in;

   entry_type            slot_mem [MAX_SLOTS];
   entry_type            rd_q;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   entry_type            wr_data;

   logic                 req_take;
   logic                 out_free;
   logic                 issue;
   logic                 match;
   logic [SIZE_BITS:0]   end_sum;

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign csr_bus.ready          = 1'b1;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.alloc_offset   = offset_ff;
   assign rsp_bus.reserved_total = total_ff;

   assign req_take = req_bus.valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign issue    = rd_idx_ff < count_ff;
   assign rd_addr  = rd_idx_ff[IDX_W-1:0];
   assign end_sum  = {1'b0, reserved_ff} + {1'b0, size_ff};

   always_comb begin
      if (func_ff == FUNC_ALLOC) begin
         match = chk_ff && !rd_q.busy && (rd_q.bytes >= size_ff);
      end else begin
         match = chk_ff && (rd_q.start == foff_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      reserved_in  = reserved_ff;
      rd_idx_in    = rd_idx_ff;
      chk_in       = chk_ff;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_slot_in  = hit_slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      offset_in    = offset_ff;
      total_in     = total_ff;
      wr_en        = 1'b0;
      wr_addr      = hit_idx_ff;
      wr_data      = hit_slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in  = S_SCAN;
               rd_idx_in = '0;
               chk_in    = 1'b0;
            end
         end
         S_SCAN: begin
            if (match) begin
               state_in    = S_DONE;
               chk_in      = 1'b0;
               hit_in      = 1'b1;
               hit_idx_in  = chk_idx_ff;
               hit_slot_in = rd_q;
            end else if (!chk_ff && !issue) begin
               state_in = S_DONE;
               hit_in   = 1'b0;
            end else begin
               chk_in     = issue;
               chk_idx_in = rd_idx_ff[IDX_W-1:0];
               if (issue) begin
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               offset_in    = '0;
               total_in     = reserved_ff;
               if (func_ff == FUNC_ALLOC) begin
                  if (hit_ff) begin
                     wr_en        = 1'b1;
                     wr_data.busy = 1'b1;
                     status_in    = ST_REUSED;
                     offset_in    = hit_slot_ff.start;
                  end else if (end_sum > {1'b0, buffer_ff}) begin
                     status_in = ST_NO_SPACE;
                  end else if (count_ff == CNT_W'(MAX_SLOTS)) begin
                     status_in = ST_TABLE_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     wr_addr       = count_ff[IDX_W-1:0];
                     wr_data.busy  = 1'b1;
                     wr_data.bytes = size_ff;
                     wr_data.start = reserved_ff;
                     count_in      = count_ff + CNT_W'(1);
                     reserved_in   = end_sum[SIZE_BITS-1:0];
                     total_in      = end_sum[SIZE_BITS-1:0];
                     status_in     = ST_NEW;
                     offset_in     = reserved_ff;
                  end
               end else begin
                  if (hit_ff) begin
                     wr_en        = 1'b1;
                     wr_data.busy = 1'b0;
                     status_in    = ST_FREED;
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         buffer_ff    <= SIZE_BITS'(BUFFER_RESET);
         count_ff     <= '0;
         reserved_ff  <= '0;
         rd_idx_ff    <= '0;
         chk_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         reserved_ff  <= reserved_in;
         rd_idx_ff    <= rd_idx_in;
         chk_ff       <= chk_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            buffer_ff <= csr_bus.buffer_bytes;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff <= req_bus.func;
         size_ff <= req_bus.req_size;
         foff_ff <= req_bus.free_offset;
      end
      chk_idx_ff  <= chk_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_slot_ff <= hit_slot_in;
      status_ff   <= status_in;
      offset_ff   <= offset_in;
      total_ff    <= total_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_q <= slot_mem[rd_addr];
   end

endmodule

`default_nettype wire
